### hw/rtl/gvc_pkg.sv
// ---------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants of the gravity vector calibrator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gvc_pkg;

    // request types
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_ORIENT = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // calibration status codes
    localparam logic [2:0] CST_NONE    = 3'd0;
    localparam logic [2:0] CST_STARTED = 3'd1;
    localparam logic [2:0] CST_DONE_OK = 3'd2;
    localparam logic [2:0] CST_FAILED  = 3'd3;
    localparam logic [2:0] CST_BUSY    = 3'd4;

    // sequencing
    localparam int SUM_W      = 48;
    localparam int DIV_W      = SUM_W + 1;
    localparam int CNT_W      = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);
    localparam logic [CNT_W-1:0] ROT_OPS   = 6'd9;
    localparam logic [CNT_W-1:0] ROT_LAST  = 6'd10;
    localparam logic [CNT_W-1:0] QUAT_OPS  = 6'd10;
    localparam logic [CNT_W-1:0] QUAT_LAST = 6'd10;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       eval;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       clear_sums;
        logic       mul_go;
        logic       mul_rot;
        logic       dst_meas;
        logic [3:0] qidx;
        logic [1:0] row;
        logic [1:0] col;
        logic       qmat;
        logic       emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic close_ok;
        logic qload;
        logic meas_en;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

### hw/rtl/gvc_in_if.sv
// ---------------------------------------------------------------------------
// gvc_in_if
// Request channel: sample, orientation update or start request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gvc_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  req_type;
    logic        [31:0] timestamp_ms;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, req_type, timestamp_ms, acc_x, acc_y, acc_z,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, req_type, timestamp_ms, acc_x, acc_y, acc_z,
                    quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

### hw/rtl/gvc_out_if.sv
// ---------------------------------------------------------------------------
// gvc_out_if
// Result channel: measured vector, calibrated gravity and status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gvc_out_if;
    logic               valid;
    logic               ready;
    logic               meas_valid;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic signed [31:0] cal_x;
    logic signed [31:0] cal_y;
    logic signed [31:0] cal_z;
    logic        [2:0]  cal_status;
    logic               calibrating;

    modport source (output valid, meas_valid, meas_x, meas_y, meas_z, cal_x, cal_y,
                    cal_z, cal_status, calibrating, input ready);
    modport sink   (input valid, meas_valid, meas_x, meas_y, meas_z, cal_x, cal_y,
                    cal_z, cal_status, calibrating, output ready);
endinterface

`default_nettype wire

### hw/rtl/gravity_vector_calibrator_core.sv
// One transaction in flight. Rate is set by the shared 32x33 multiplier
// (9 rotation products, 10 quaternion products), the 49-step restoring
// divider on window close and back-pressure on the result channel.
// Reset (synchronous, active low) clears the window and output valid and
// loads the default configuration and calibrated gravity.
// ---------------------------------------------------------------------------
// gravity_vector_calibrator_core
// Top level: configuration registers, sequencer and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gravity_vector_calibrator_core import gvc_pkg::*; #(
    parameter int COUNT_BITS     = 16,
    parameter int ACC_FRAC_BITS  = 16,
    parameter int QUAT_FRAC_BITS = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gvc_in_if.sink           i_in,
    gvc_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [19:0] r_auto_dur, r_man_dur;
    t_cmd        cmd;
    t_stat       stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_dur <= 20'd0;
            r_man_dur  <= 20'd2000;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_man_dur <= pwdata[19:0];
            else r_auto_dur <= pwdata[19:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {12'd0, r_man_dur} : {12'd0, r_auto_dur};

    gvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gvc_datapath #(
        .COUNT_BITS     (COUNT_BITS),
        .ACC_FRAC_BITS  (ACC_FRAC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_auto_dur     (r_auto_dur),
        .i_man_dur      (r_man_dur),
        .i_req_type     (i_in.req_type),
        .i_timestamp_ms (i_in.timestamp_ms),
        .i_acc_x        (i_in.acc_x),
        .i_acc_y        (i_in.acc_y),
        .i_acc_z        (i_in.acc_z),
        .i_quat_w       (i_in.quat_w),
        .i_quat_x       (i_in.quat_x),
        .i_quat_y       (i_in.quat_y),
        .i_quat_z       (i_in.quat_z),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire

### hw/rtl/gvc_datapath.sv
// ---------------------------------------------------------------------------
// gvc_datapath
// Window bookkeeping, sum registers, three-lane divider, shared multiplier
// for quaternion products and matrix rotation, and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gvc_datapath import gvc_pkg::*; #(
    parameter int COUNT_BITS     = 16,
    parameter int ACC_FRAC_BITS  = 16,
    parameter int QUAT_FRAC_BITS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic        [19:0] i_auto_dur,
    input  wire logic        [19:0] i_man_dur,
    input  wire logic        [1:0]  i_req_type,
    input  wire logic        [31:0] i_timestamp_ms,
    input  wire logic signed [31:0] i_acc_x,
    input  wire logic signed [31:0] i_acc_y,
    input  wire logic signed [31:0] i_acc_z,
    input  wire logic signed [31:0] i_quat_w,
    input  wire logic signed [31:0] i_quat_x,
    input  wire logic signed [31:0] i_quat_y,
    input  wire logic signed [31:0] i_quat_z,
    gvc_out_if.source               o_out
);

    localparam int Q    = QUAT_FRAC_BITS;
    localparam int CB   = COUNT_BITS;
    localparam int QP_W = 66 - Q;
    localparam int MS_W = QP_W + 3;
    localparam int M_W  = Q + 2;
    localparam logic signed [67:0] HALF    = 68'sd1 <<< (Q - 1);
    localparam logic signed [67:0] I32_MAX = 68'sd2147483647;
    localparam logic signed [67:0] I32_MIN = -68'sd2147483648;
    localparam logic signed [MS_W-1:0] M_ONE = $signed(MS_W'(1) << Q);
    localparam logic signed [MS_W-1:0] M_NEG = -M_ONE;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh800000000000;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam longint GZ_MAG = ((longint'(980665) << ACC_FRAC_BITS) + 50000) / 100000;
    localparam logic signed [31:0] GRAV_Z_RST = 32'(-GZ_MAG);
    localparam logic [DIV_W-1:0] Q_POS_LIM = DIV_W'(32'h7FFFFFFF);
    localparam logic [DIV_W-1:0] Q_NEG_LIM = DIV_W'(32'h80000000);

    // captured request
    logic        [1:0]  r_req;
    logic        [31:0] r_ts;
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_q   [4];

    // calibration state
    logic               r_wo, r_ad, r_ok;
    logic        [31:0] r_ws;
    logic        [19:0] r_wl;
    logic     [CB-1:0]  r_cnt;
    logic signed [47:0] r_sum  [3];
    logic signed [31:0] r_grav [3];
    logic        [2:0]  r_status;

    // rotation matrix
    logic signed [QP_W-1:0] r_qp [10];
    logic signed [M_W-1:0]  r_m  [3][3];
    logic signed [M_W-1:0]  n_m  [3][3];

    // divider lanes
    logic [DIV_W-1:0]   r_dq   [3];
    logic [CB-1:0]      r_rem  [3];
    logic               r_sneg [3];
    logic signed [32:0] r_nm   [3];

    // multiplier pipeline
    logic                r_p_vld, r_p_rot, r_p_dst;
    logic [3:0]          r_p_qidx;
    logic [1:0]          r_p_row, r_p_col;
    logic signed [64:0]  r_prod;
    logic signed [67:0]  r_racc;
    logic                r_f_vld, r_f_dst;
    logic [1:0]          r_f_row;
    logic signed [67:0]  r_fin;
    logic signed [31:0]  r_meas [3];

    // result register
    logic               r_out_vld, r_o_mv, r_o_cw;
    logic signed [31:0] r_o_meas [3];
    logic signed [31:0] r_o_cal  [3];
    logic        [2:0]  r_o_st;

    // eval results
    logic               e_wo, e_ad, e_ok, e_close_ok;
    logic        [31:0] e_ws, elapsed;
    logic        [19:0] e_wl;
    logic     [CB-1:0]  e_cnt;
    logic signed [47:0] e_sum [3];
    logic        [2:0]  e_st;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [32:0] vsel [3];
    logic signed [67:0] rot_sum, qr_t, fin_r;
    logic signed [31:0] fin_v;

    logic [DIV_W-1:0] d_init [3];
    logic [DIV_W-1:0] d_next [3];
    logic [CB-1:0]    r_next [3];
    logic signed [32:0] d_nm [3];

    // quaternion part feeding each product
    function automatic logic [1:0] qsel_a(input logic [3:0] k);
        unique case (k)
            4'd1, 4'd4, 4'd5: qsel_a = 2'd1;
            4'd2, 4'd6:       qsel_a = 2'd2;
            4'd3:             qsel_a = 2'd3;
            default:          qsel_a = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] qsel_b(input logic [3:0] k);
        unique case (k)
            4'd1, 4'd7:             qsel_b = 2'd1;
            4'd2, 4'd4, 4'd8:       qsel_b = 2'd2;
            4'd3, 4'd5, 4'd6, 4'd9: qsel_b = 2'd3;
            default:                qsel_b = 2'd0;
        endcase
    endfunction

    function automatic logic signed [M_W-1:0] clampm(input logic signed [MS_W-1:0] v);
        if (v > M_ONE) clampm = M_W'(M_ONE);
        else if (v < M_NEG) clampm = M_W'(M_NEG);
        else clampm = M_W'(v);
    endfunction

    // request bookkeeping
    always_comb begin
        logic signed [48:0] t;
        e_wo = r_wo; e_ad = r_ad; e_ok = r_ok; e_ws = r_ws; e_wl = r_wl;
        e_cnt = r_cnt; e_st = CST_NONE; e_close_ok = 1'b0; elapsed = '0;
        for (int i = 0; i < 3; i++) e_sum[i] = r_sum[i];
        unique case (r_req)
            REQ_SAMPLE: begin
                if (i_auto_dur != 20'd0 && !r_ad) begin
                    if (r_wo) begin
                        e_st = CST_BUSY;
                    end else begin
                        e_wo = 1'b1; e_ws = r_ts; e_wl = i_auto_dur; e_cnt = '0;
                        for (int i = 0; i < 3; i++) e_sum[i] = '0;
                        e_st = CST_STARTED;
                    end
                    e_ad = 1'b1;
                end
                if (e_wo) begin
                    elapsed = r_ts - e_ws;
                    if (elapsed < {12'd0, e_wl}) begin
                        if (e_cnt != CNT_MAX) begin
                            e_cnt = e_cnt + CB'(1);
                            for (int i = 0; i < 3; i++) begin
                                t = {e_sum[i][47], e_sum[i]} + 49'(r_acc[i]);
                                if (t[48] != t[47]) e_sum[i] = t[48] ? SUM_MIN : SUM_MAX;
                                else e_sum[i] = t[47:0];
                            end
                        end
                    end else begin
                        e_wo = 1'b0;
                        if (e_cnt == '0 || !r_ok) begin
                            e_st = CST_FAILED; e_cnt = '0;
                            for (int i = 0; i < 3; i++) e_sum[i] = '0;
                        end else begin
                            e_st = CST_DONE_OK; e_close_ok = 1'b1;
                        end
                    end
                end
            end
            REQ_ORIENT: e_ok = 1'b1;
            REQ_START: begin
                if (r_wo) begin
                    e_st = CST_BUSY;
                end else begin
                    e_wo = 1'b1; e_ws = r_ts; e_wl = i_man_dur; e_cnt = '0;
                    for (int i = 0; i < 3; i++) e_sum[i] = '0;
                    e_st = CST_STARTED;
                end
            end
            default: e_st = CST_NONE;
        endcase
    end

    assign o_stat.close_ok = e_close_ok;
    assign o_stat.qload    = (r_req == REQ_ORIENT);
    assign o_stat.meas_en  = (r_req == REQ_SAMPLE) && r_ok;
    assign o_stat.out_busy = r_out_vld && !o_out.ready;

    // divider lanes: rounded magnitude quotient, then clamped and negated
    always_comb begin
        logic [47:0]   mag;
        logic [CB:0]   sh;
        logic [31:0]   lim;
        for (int i = 0; i < 3; i++) begin
            mag = r_sum[i][47] ? 48'(-r_sum[i]) : r_sum[i];
            d_init[i] = {1'b0, mag} + DIV_W'(r_cnt >> 1);
            sh = {r_rem[i], r_dq[i][DIV_W-1]};
            if (sh >= {1'b0, r_cnt}) begin
                r_next[i] = CB'(sh - {1'b0, r_cnt});
                d_next[i] = {r_dq[i][DIV_W-2:0], 1'b1};
            end else begin
                r_next[i] = CB'(sh);
                d_next[i] = {r_dq[i][DIV_W-2:0], 1'b0};
            end
            if (r_sneg[i]) lim = (r_dq[i] > Q_NEG_LIM) ? 32'h80000000 : r_dq[i][31:0];
            else lim = (r_dq[i] > Q_POS_LIM) ? 32'h7FFFFFFF : r_dq[i][31:0];
            // negated mean: a negative sum gives a positive entry
            d_nm[i] = r_sneg[i] ? $signed({1'b0, lim}) : 33'sd0 - $signed({1'b0, lim});
        end
    end

    // matrix entries from rounded quaternion products
    always_comb begin
        logic signed [MS_W-1:0] s [10];
        for (int k = 0; k < 10; k++) s[k] = MS_W'(r_qp[k]);
        n_m[0][0] = clampm(s[0] + s[1] - s[2] - s[3]);
        n_m[0][1] = clampm((s[4] - s[9]) <<< 1);
        n_m[0][2] = clampm((s[5] + s[8]) <<< 1);
        n_m[1][0] = clampm((s[4] + s[9]) <<< 1);
        n_m[1][1] = clampm(s[0] - s[1] + s[2] - s[3]);
        n_m[1][2] = clampm((s[6] - s[7]) <<< 1);
        n_m[2][0] = clampm((s[5] - s[8]) <<< 1);
        n_m[2][1] = clampm((s[6] + s[7]) <<< 1);
        n_m[2][2] = clampm(s[0] - s[1] - s[2] + s[3]);
    end

    // shared multiplier operand select
    always_comb begin
        for (int j = 0; j < 3; j++)
            vsel[j] = i_cmd.dst_meas ? -(33'(r_acc[j])) : r_nm[j];
        if (i_cmd.mul_rot) begin
            mul_a = 32'(r_m[i_cmd.row][i_cmd.col]);
            mul_b = vsel[i_cmd.col];
        end else begin
            mul_a = r_q[qsel_a(i_cmd.qidx)];
            mul_b = 33'(r_q[qsel_b(i_cmd.qidx)]);
        end
    end

    assign mul_p   = 65'(mul_a) * 65'(mul_b);
    assign qr_t    = (68'(r_prod) + HALF) >>> Q;
    assign rot_sum = ((r_p_col == 2'd0) ? 68'sd0 : r_racc) + 68'(r_prod);
    assign fin_r   = (r_fin + HALF) >>> Q;
    assign fin_v   = (fin_r > I32_MAX) ? 32'sh7FFFFFFF :
                     (fin_r < I32_MIN) ? 32'sh80000000 : fin_r[31:0];

    // control state and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wo <= 1'b0; r_ad <= 1'b0; r_ok <= 1'b0;
            r_ws <= '0; r_wl <= '0; r_cnt <= '0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            r_grav[0] <= '0; r_grav[1] <= '0; r_grav[2] <= GRAV_Z_RST;
            r_out_vld <= 1'b0; r_p_vld <= 1'b0; r_f_vld <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_wo <= e_wo; r_ad <= e_ad; r_ok <= e_ok;
                r_ws <= e_ws; r_wl <= e_wl; r_cnt <= e_cnt;
                for (int i = 0; i < 3; i++) r_sum[i] <= e_sum[i];
            end
            if (i_cmd.clear_sums) begin
                r_cnt <= '0;
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            end
            r_p_vld <= i_cmd.mul_go;
            r_f_vld <= r_p_vld && r_p_rot && (r_p_col == 2'd2);
            if (r_f_vld && !r_f_dst) r_grav[r_f_row] <= fin_v;
            // result register handshake
            if (i_cmd.emit) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type; r_ts <= i_timestamp_ms;
            r_acc[0] <= i_acc_x; r_acc[1] <= i_acc_y; r_acc[2] <= i_acc_z;
            if (i_req_type == REQ_ORIENT) begin
                r_q[0] <= i_quat_w; r_q[1] <= i_quat_x;
                r_q[2] <= i_quat_y; r_q[3] <= i_quat_z;
            end
        end
        if (i_cmd.eval) r_status <= e_st;
        // divider
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.div_init) begin
                r_dq[i] <= d_init[i]; r_rem[i] <= '0; r_sneg[i] <= r_sum[i][47];
            end else if (i_cmd.div_step) begin
                r_dq[i] <= d_next[i]; r_rem[i] <= r_next[i];
            end
            if (i_cmd.div_store) r_nm[i] <= d_nm[i];
        end
        // multiplier stage
        r_prod <= mul_p; r_p_rot <= i_cmd.mul_rot; r_p_dst <= i_cmd.dst_meas;
        r_p_qidx <= i_cmd.qidx; r_p_row <= i_cmd.row; r_p_col <= i_cmd.col;
        // accumulate stage
        if (r_p_vld) begin
            if (!r_p_rot) r_qp[r_p_qidx] <= QP_W'(qr_t);
            else if (r_p_col == 2'd2) r_fin <= rot_sum;
            else r_racc <= rot_sum;
        end
        r_f_dst <= r_p_dst; r_f_row <= r_p_row;
        if (r_f_vld && r_f_dst) r_meas[r_f_row] <= fin_v;
        if (i_cmd.qmat) r_m <= n_m;
        // result capture
        if (i_cmd.emit) begin
            r_o_mv <= o_stat.meas_en;
            for (int i = 0; i < 3; i++) begin
                r_o_meas[i] <= o_stat.meas_en ? r_meas[i] : 32'sd0;
                r_o_cal[i]  <= r_grav[i];
            end
            r_o_st <= r_status; r_o_cw <= r_wo;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.meas_valid  = r_o_mv;
    assign o_out.meas_x      = r_o_meas[0];
    assign o_out.meas_y      = r_o_meas[1];
    assign o_out.meas_z      = r_o_meas[2];
    assign o_out.cal_x       = r_o_cal[0];
    assign o_out.cal_y       = r_o_cal[1];
    assign o_out.cal_z       = r_o_cal[2];
    assign o_out.cal_status  = r_o_st;
    assign o_out.calibrating = r_o_cw;

endmodule

`default_nettype wire

### hw/rtl/gvc_ctrl.sv
// ---------------------------------------------------------------------------
// gvc_ctrl
// Sequencer: evaluates a request, runs division, matrix build and rotations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gvc_ctrl import gvc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_RCAL  = 8'b0000_1000,
        S_RMEAS = 8'b0001_0000,
        S_QMUL  = 8'b0010_0000,
        S_QMAT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_row, n_row, r_col, n_col;

    // next state and commands
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_row = r_row; n_col = r_col;
        o_cmd = '0; o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1; n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1; n_cnt = '0; n_row = '0; n_col = '0;
                if (i_stat.close_ok) begin
                    o_cmd.div_init = 1'b1; n_state = S_DIV;
                end else if (i_stat.qload) n_state = S_QMUL;
                else if (i_stat.meas_en) n_state = S_RMEAS;
                else n_state = S_EMIT;
            end
            S_DIV: begin
                if (r_cnt == DIV_STEPS) begin
                    o_cmd.div_store = 1'b1; n_cnt = '0; n_state = S_RCAL;
                end else begin
                    o_cmd.div_step = 1'b1; n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_RCAL, S_RMEAS: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt < ROT_OPS) begin
                    o_cmd.mul_go = 1'b1; o_cmd.mul_rot = 1'b1;
                    o_cmd.dst_meas = (r_state == S_RMEAS);
                    o_cmd.row = r_row; o_cmd.col = r_col;
                    if (r_col == 2'd2) begin
                        n_col = '0; n_row = r_row + 2'd1;
                    end else n_col = r_col + 2'd1;
                end
                if (r_cnt == ROT_LAST) begin
                    n_cnt = '0; n_row = '0; n_col = '0;
                    if (r_state == S_RCAL) begin
                        o_cmd.clear_sums = 1'b1;
                        n_state = i_stat.meas_en ? S_RMEAS : S_EMIT;
                    end else n_state = S_EMIT;
                end
            end
            S_QMUL: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt < QUAT_OPS) begin
                    o_cmd.mul_go = 1'b1; o_cmd.qidx = r_cnt[3:0];
                end
                if (r_cnt == QUAT_LAST) n_state = S_QMAT;
            end
            S_QMAT: begin
                o_cmd.qmat = 1'b1; n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_row <= '0; r_col <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_row <= n_row; r_col <= n_col;
        end
    end

endmodule

`default_nettype wire
